// ----- rtl/krfp_pkg.sv -----
// Package of types and codes shared by the K-line response frame parser files.
`timescale 1ns / 1ps
`default_nettype none
package krfp_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 128;

	// status codes of an end of frame result
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ERROR    = 3'd1;
	localparam logic [2:0] ST_NEGATIVE = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_BAD_SUM  = 3'd4;

	// error causes
	localparam logic [1:0] EC_NONE     = 2'd0;
	localparam logic [1:0] EC_TIMEOUT  = 2'd1;
	localparam logic [1:0] EC_ZERO_LEN = 2'd2;

	// operation and result kinds
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] service_id;
		logic [2:0] status;
		logic       checksum_good;
		logic [7:0] kept_count;
		logic [1:0] error_cause;
		logic       address_present;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/krfp_if.sv -----
// Valid/ready channel interfaces for items, results and the configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface krfp_item_if;
	import krfp_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface krfp_result_if;
	import krfp_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface krfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/kline_response_frame_parser.sv -----
// Top level of the K-line (ISO 14230-2) response frame parser.
//
// Usage:
//  - item: one transfer per received byte (operation 0) or per inter-byte
//    timeout (operation 1). Bytes first pass an echo discard of echo_skip
//    bytes, then the format byte, optional address pair, optional length
//    byte, service id, payload and checksum are parsed.
//  - result: one transfer per kept payload byte (kind 0) and one status
//    transfer (kind 1) at the checksum byte, a timeout or a zero length.
//  - cfg: a single write-only register, echo_skip; always ready. Write it
//    only while the block is idle; in the echo phase it restarts the count.
// Path: an accepted item lands in the input register, is parsed from there
// and its result is loaded into the result register when the item advances;
// a stalled result can hold that advance off.
// Throughput: one item per cycle while no result stalls; the per-byte parse
// is a small state update between the input register and the result register.
// Reset: arst_n clears the frame state to the echo phase, echo_skip to zero
// and drops both valid flags.
// Stall: while a result waits and result.ready is low, an item that makes
// no result still advances; one that makes a result holds in the input
// register and item.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module kline_response_frame_parser #(
	parameter int unsigned MAX_PAYLOAD = krfp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	krfp_cfg_if.sink       cfg,
	krfp_item_if.sink      item,
	krfp_result_if.source  result
);
	import krfp_pkg::*;

	// parse phases
	localparam logic [2:0] PH_ECHO   = 3'd0;
	localparam logic [2:0] PH_ADDR   = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_SID    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CSUM   = 3'd5;

	localparam logic [7:0] MaxKept = 8'(MAX_PAYLOAD);
	localparam logic [7:0] SidNegative = 8'h7F;

	// configuration
	logic [8:0] echo_skip_q;

	// frame state
	logic [2:0] phase_q;
	logic [8:0] echo_left_q;
	logic [1:0] address_left_q;
	logic [7:0] bytes_left_q;
	logic [7:0] running_sum_q;
	logic [7:0] sid_held_q;
	logic [7:0] kept_bytes_q;
	logic       overflowed_q;
	logic       address_seen_q;

	// next state from the parse
	logic [2:0] phase_d;
	logic [8:0] echo_left_d;
	logic [1:0] address_left_d;
	logic [7:0] bytes_left_d;
	logic [7:0] running_sum_d;
	logic [7:0] sid_held_d;
	logic [7:0] kept_bytes_d;
	logic       overflowed_d;
	logic       address_seen_d;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;

	logic    produce;
	result_t res_d;
	logic    restart;
	logic    advance;
	logic    item_xfer;
	logic    cfg_xfer;
	logic [1:0] mode;
	logic [7:0] sum_add;
	logic    good;

	assign cfg.ready = 1'b1;
	assign cfg_xfer  = cfg.valid;

	// Advance the input register unless its result would overwrite one
	// still waiting on a stalled receiver.
	assign advance    = valid_s1 && (!res_valid_q || result.ready || !produce);
	assign item.ready = !valid_s1 || advance;
	assign item_xfer  = item.valid && item.ready;

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	assign mode    = item_s1.rx_byte[7:6];
	assign sum_add = running_sum_q + item_s1.rx_byte;
	assign good    = (running_sum_q == item_s1.rx_byte);

	always_comb begin
		phase_d        = phase_q;
		echo_left_d    = echo_left_q;
		address_left_d = address_left_q;
		bytes_left_d   = bytes_left_q;
		running_sum_d  = running_sum_q;
		sid_held_d     = sid_held_q;
		kept_bytes_d   = kept_bytes_q;
		overflowed_d   = overflowed_q;
		address_seen_d = address_seen_q;
		produce        = 1'b0;
		restart        = 1'b0;
		res_d                 = '0;
		res_d.service_id      = sid_held_q;
		res_d.kept_count      = kept_bytes_q;
		res_d.address_present = address_seen_q;

		if (item_s1.operation == OP_TIMEOUT) begin
			// a timeout ends the frame in any phase
			produce           = 1'b1;
			restart           = 1'b1;
			res_d.kind        = KIND_STATUS;
			res_d.status      = ST_ERROR;
			res_d.error_cause = EC_TIMEOUT;
		end else begin
			unique case (phase_q)
				PH_ECHO: begin
					if (echo_left_q != 9'd0) begin
						echo_left_d = echo_left_q - 9'd1;
					end else begin
						running_sum_d = item_s1.rx_byte;
						bytes_left_d  = {2'b00, item_s1.rx_byte[5:0]};
						// physical or functional addressing carries the address pair
						if (mode == 2'b10 || mode == 2'b11) begin
							address_seen_d = 1'b1;
							address_left_d = 2'd2;
							phase_d        = PH_ADDR;
						end else begin
							phase_d = (item_s1.rx_byte[5:0] == 6'd0) ? PH_EXTLEN : PH_SID;
						end
					end
				end
				PH_ADDR: begin
					running_sum_d  = sum_add;
					address_left_d = address_left_q - 2'd1;
					if (address_left_q == 2'd1) begin
						phase_d = (bytes_left_q == 8'd0) ? PH_EXTLEN : PH_SID;
					end
				end
				PH_EXTLEN: begin
					running_sum_d = sum_add;
					if (item_s1.rx_byte == 8'd0) begin
						produce           = 1'b1;
						restart           = 1'b1;
						res_d.kind        = KIND_STATUS;
						res_d.status      = ST_ERROR;
						res_d.error_cause = EC_ZERO_LEN;
					end else begin
						bytes_left_d = item_s1.rx_byte;
						phase_d      = PH_SID;
					end
				end
				PH_SID: begin
					sid_held_d    = item_s1.rx_byte;
					running_sum_d = sum_add;
					bytes_left_d  = bytes_left_q - 8'd1;
					phase_d       = (bytes_left_q == 8'd1) ? PH_CSUM : PH_DATA;
				end
				PH_DATA: begin
					running_sum_d = sum_add;
					if (kept_bytes_q < MaxKept) begin
						kept_bytes_d        = kept_bytes_q + 8'd1;
						produce             = 1'b1;
						res_d.kind          = KIND_DATA;
						res_d.payload_byte  = item_s1.rx_byte;
						res_d.payload_index = kept_bytes_q;
						res_d.kept_count    = kept_bytes_q + 8'd1;
					end else begin
						overflowed_d = 1'b1;
					end
					bytes_left_d = bytes_left_q - 8'd1;
					if (bytes_left_q == 8'd1) begin
						phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					produce             = 1'b1;
					restart             = 1'b1;
					res_d.kind          = KIND_STATUS;
					res_d.checksum_good = good;
					priority if (sid_held_q == SidNegative) begin
						res_d.status = ST_NEGATIVE;
					end else if (overflowed_q) begin
						res_d.status = ST_OVERFLOW;
					end else if (!good) begin
						res_d.status = ST_BAD_SUM;
					end else begin
						res_d.status = ST_OK;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end

		// back to the start of a frame
		if (restart) begin
			phase_d        = PH_ECHO;
			echo_left_d    = echo_skip_q;
			address_left_d = 2'd0;
			bytes_left_d   = 8'd0;
			running_sum_d  = 8'd0;
			sid_held_d     = 8'd0;
			kept_bytes_d   = 8'd0;
			overflowed_d   = 1'b0;
			address_seen_d = 1'b0;
		end
	end

	// frame state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_skip_q    <= 9'd0;
			phase_q        <= PH_ECHO;
			echo_left_q    <= 9'd0;
			address_left_q <= 2'd0;
			bytes_left_q   <= 8'd0;
			running_sum_q  <= 8'd0;
			sid_held_q     <= 8'd0;
			kept_bytes_q   <= 8'd0;
			overflowed_q   <= 1'b0;
			address_seen_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q        <= phase_d;
				echo_left_q    <= echo_left_d;
				address_left_q <= address_left_d;
				bytes_left_q   <= bytes_left_d;
				running_sum_q  <= running_sum_d;
				sid_held_q     <= sid_held_d;
				kept_bytes_q   <= kept_bytes_d;
				overflowed_q   <= overflowed_d;
				address_seen_q <= address_seen_d;
			end
			// a write in the echo phase restarts the echo count
			if (cfg_xfer) begin
				echo_skip_q <= cfg.data;
				if (phase_q == PH_ECHO) begin
					echo_left_q <= cfg.data;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_s1 <= item.payload;
		end
	end

	// result register: load on a producing advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produce) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/krfp_checker.sv -----
// Port-level checker for the K-line response frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module krfp_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                res_valid,
	input wire                res_ready,
	input krfp_pkg::result_t  res
);
	import krfp_pkg::*;

	// a stalled result holds its content
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a payload result carries no status information
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_DATA |->
		res.status == ST_OK && res.error_cause == EC_NONE && !res.checksum_good
		&& res.kept_count == res.payload_index + 8'd1)
		else $error("payload result with status fields set");

	// an error cause appears exactly with the error status
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_STATUS |->
		(res.status == ST_ERROR) == (res.error_cause != EC_NONE))
		else $error("error cause and status disagree");

	// a good checksum on a plain frame must report ok
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_STATUS && res.checksum_good
		&& res.service_id != 8'h7F && res.status != ST_OVERFLOW |->
		res.status == ST_OK)
		else $error("good checksum reported as failure");

endmodule

bind kline_response_frame_parser krfp_checker u_krfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res       (result.payload)
);
`default_nettype wire

// ----- dv/kline_response_frame_parser_test.sv -----
// Self-checking testbench for the K-line response frame parser.
`timescale 1ns / 1ps
module kline_response_frame_parser_test;
	import krfp_pkg::*;

	localparam int KEEP_LIMIT  = MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 35;
	localparam int NO_CUT      = -1;

	// format byte fields and the negative response service id
	localparam logic [7:0] MODE_MASK    = 8'hC0;
	localparam logic [7:0] MODE_PHYS    = 8'h80;
	localparam logic [7:0] MODE_FUNC    = 8'hC0;
	localparam logic [7:0] LEN_MASK     = 8'h3F;
	localparam logic [7:0] SID_NEGATIVE = 8'h7F;

	typedef enum logic [2:0] {
		FR_ECHO, FR_ADDR, FR_EXTLEN, FR_SID, FR_DATA, FR_CHECKSUM
	} frame_phase_e;

	logic clk;
	logic arst_n;

	krfp_cfg_if    cfg_ch ();
	krfp_item_if   item_ch ();
	krfp_result_if result_ch ();

	kline_response_frame_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Stimulus waiting for the driver, and parser outputs still owed by the block.
	item_t   rx_items[$];
	result_t outputs_due[$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  stim_count  = 0;
	int  echo_setting = 0;
	bit  quiet = 1'b0;
	bit  item_taken = 1'b0;
	int  src_gap = 0;
	int  sink_gap = 0;

	// Own copy of the parser state, at reset values.
	logic [8:0]   echo_skip_reg = '0;
	frame_phase_e fr_phase = FR_ECHO;
	logic [8:0]   echo_left = '0;
	logic [1:0]   addr_left = '0;
	logic [7:0]   bytes_left = '0;
	logic [7:0]   run_sum = '0;
	logic [7:0]   sid_held = '0;
	logic [7:0]   kept = '0;
	logic         overflowed = 1'b0;
	logic         addr_seen = 1'b0;

	// ---------------------------------------------------------------
	// Frame parser prediction
	// ---------------------------------------------------------------

	// Emit the end of frame status and fall back to the echo phase.
	task automatic close_frame(input logic [2:0] st, input logic good, input logic [1:0] cause);
		result_t r;
		r = '0;
		r.kind            = KIND_STATUS;
		r.service_id      = sid_held;
		r.status          = st;
		r.checksum_good   = good;
		r.kept_count      = kept;
		r.error_cause     = cause;
		r.address_present = addr_seen;
		outputs_due.push_back(r);
		fr_phase   = FR_ECHO;
		echo_left  = echo_skip_reg;
		addr_left  = '0;
		bytes_left = '0;
		run_sum    = '0;
		sid_held   = '0;
		kept       = '0;
		overflowed = 1'b0;
		addr_seen  = 1'b0;
	endtask

	task automatic parse_rx_item(input item_t it);
		result_t    r;
		logic [7:0] b;
		logic       good;
		logic [2:0] st;
		b = it.rx_byte;
		// a timeout ends the frame in any phase
		if (it.operation == OP_TIMEOUT) begin
			close_frame(ST_ERROR, 1'b0, EC_TIMEOUT);
			return;
		end
		case (fr_phase)
			FR_ECHO: begin
				if (echo_left != 0) begin
					echo_left = echo_left - 1'b1;
				end else begin
					run_sum    = b;
					bytes_left = b & LEN_MASK;
					if ((b & MODE_MASK) == MODE_PHYS || (b & MODE_MASK) == MODE_FUNC) begin
						addr_seen = 1'b1;
						addr_left = 2'd2;
						fr_phase  = FR_ADDR;
					end else begin
						fr_phase = (bytes_left == 0) ? FR_EXTLEN : FR_SID;
					end
				end
			end
			FR_ADDR: begin
				run_sum   = run_sum + b;
				addr_left = addr_left - 1'b1;
				if (addr_left == 0)
					fr_phase = (bytes_left == 0) ? FR_EXTLEN : FR_SID;
			end
			FR_EXTLEN: begin
				run_sum = run_sum + b;
				if (b == 0) begin
					close_frame(ST_ERROR, 1'b0, EC_ZERO_LEN);
				end else begin
					bytes_left = b;
					fr_phase   = FR_SID;
				end
			end
			FR_SID: begin
				sid_held   = b;
				run_sum    = run_sum + b;
				bytes_left = bytes_left - 1'b1;
				fr_phase   = (bytes_left == 0) ? FR_CHECKSUM : FR_DATA;
			end
			FR_DATA: begin
				run_sum = run_sum + b;
				// keep up to the buffer limit, then only sum and flag the overflow
				if (kept < KEEP_LIMIT) begin
					r = '0;
					r.kind            = KIND_DATA;
					r.payload_byte    = b;
					r.payload_index   = kept;
					r.service_id      = sid_held;
					r.status          = ST_OK;
					r.kept_count      = kept + 1'b1;
					r.error_cause     = EC_NONE;
					r.address_present = addr_seen;
					kept = kept + 1'b1;
					outputs_due.push_back(r);
				end else begin
					overflowed = 1'b1;
				end
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0)
					fr_phase = FR_CHECKSUM;
			end
			FR_CHECKSUM: begin
				good = (run_sum == b);
				// negative response wins over everything, even a bad sum
				if (sid_held == SID_NEGATIVE)
					st = ST_NEGATIVE;
				else if (overflowed)
					st = ST_OVERFLOW;
				else if (!good)
					st = ST_BAD_SUM;
				else
					st = ST_OK;
				close_frame(st, good, EC_NONE);
			end
			default: begin
				fr_phase = FR_ECHO;
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// Output checking
	// ---------------------------------------------------------------

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	task automatic check_output(input result_t got);
		result_t want;
		if (outputs_due.size() == 0) begin
			$error("result transfer with nothing expected: kind %0d status %0d",
				got.kind, got.status);
			error_count++;
			return;
		end
		want = outputs_due.pop_front();
		check_field("kind", want.kind, got.kind);
		check_field("payload_byte", want.payload_byte, got.payload_byte);
		check_field("payload_index", want.payload_index, got.payload_index);
		check_field("service_id", want.service_id, got.service_id);
		check_field("status", want.status, got.status);
		check_field("checksum_good", want.checksum_good, got.checksum_good);
		check_field("kept_count", want.kept_count, got.kept_count);
		check_field("error_cause", want.error_cause, got.error_cause);
		check_field("address_present", want.address_present, got.address_present);
	endtask

	// Monitor: sample every transfer at the rising edge and advance the prediction.
	always @(posedge clk) begin
		item_taken <= item_ch.valid && item_ch.ready;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count == CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				// a register write while in the echo phase restarts the echo count
				if (cfg_ch.valid && cfg_ch.ready) begin
					echo_skip_reg = cfg_ch.data;
					if (fr_phase == FR_ECHO)
						echo_left = cfg_ch.data;
				end
				if (item_ch.valid && item_ch.ready)
					parse_rx_item(item_ch.payload);
				if (result_ch.valid && result_ch.ready)
					check_output(result_ch.payload);
			end
		end
	end

	// ---------------------------------------------------------------
	// Drivers: all inputs change at the falling edge
	// ---------------------------------------------------------------

	// Item driver: hold the current item until its transfer, then either open
	// an idle burst or present the next queued item.
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_taken)) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				item_ch.valid <= 1'b0;
			end else if (!quiet && rx_items.size() != 0 && $urandom_range(0, 15) == 0) begin
				src_gap <= $urandom_range(0, 18);
				item_ch.valid <= 1'b0;
			end else if (rx_items.size() != 0) begin
				item_ch.payload <= rx_items.pop_front();
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: stall in random bursts, never starting one in the quiet tail.
	always @(negedge clk) begin
		if (sink_gap != 0) begin
			sink_gap <= sink_gap - 1;
			result_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			sink_gap <= $urandom_range(0, 18);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Queue one response frame behind the current echo count. mode selects the
	// two top bits of the format byte; len of zero with ext set makes a zero
	// length frame; cut replaces that item (counted from the first echo byte)
	// with a timeout and drops the rest.
	task automatic queue_frame(input int mode, input int len, input bit ext, input bit bad_sum,
			input logic [7:0] sid, input int cut);
		item_t      seq[$];
		logic [7:0] fmt;
		logic [7:0] sum;
		logic [7:0] bt;
		int         i;
		for (i = 0; i < echo_setting; i++)
			seq.push_back(item_t'{OP_BYTE, 8'($urandom)});
		fmt = {2'(mode), ext ? 6'd0 : 6'(len)};
		sum = fmt;
		seq.push_back(item_t'{OP_BYTE, fmt});
		if (mode >= 2) begin
			repeat (2) begin
				bt = 8'($urandom);
				sum = sum + bt;
				seq.push_back(item_t'{OP_BYTE, bt});
			end
		end
		if (ext) begin
			sum = sum + 8'(len);
			seq.push_back(item_t'{OP_BYTE, 8'(len)});
		end
		if (len != 0) begin
			sum = sum + sid;
			seq.push_back(item_t'{OP_BYTE, sid});
			for (i = 1; i < len; i++) begin
				bt = 8'($urandom);
				sum = sum + bt;
				seq.push_back(item_t'{OP_BYTE, bt});
			end
			if (bad_sum)
				sum = sum + 8'($urandom_range(1, 255));
			seq.push_back(item_t'{OP_BYTE, sum});
		end
		for (i = 0; i < seq.size(); i++) begin
			if (i >= echo_setting)
				stim_count++;
			if (i == cut) begin
				rx_items.push_back(item_t'{OP_TIMEOUT, 8'($urandom)});
				break;
			end
			rx_items.push_back(seq[i]);
		end
	endtask

	// Mostly well-formed frames with random content; the rest is noise closed
	// by a timeout, truncated frames, zero lengths and bad sums.
	task automatic queue_random_frame();
		int         pick;
		int         len;
		int         cut;
		bit         ext;
		logic [7:0] sid;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6)) begin
				rx_items.push_back(item_t'{OP_BYTE, 8'($urandom)});
				stim_count++;
			end
			rx_items.push_back(item_t'{OP_TIMEOUT, 8'($urandom)});
			stim_count++;
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(1, 12);
		else if (pick < 90)
			len = $urandom_range(13, 63);
		else if (pick < 95)
			len = $urandom_range(64, 129);
		else
			len = $urandom_range(130, 255);
		ext = (len > 63) || ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 39) == 0) begin
			len = 0;
			ext = 1'b1;
		end
		sid = ($urandom_range(0, 9) == 0) ? SID_NEGATIVE : 8'($urandom);
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, echo_setting + len + 3) : NO_CUT;
		queue_frame($urandom_range(0, 3), len, ext, $urandom_range(0, 7) == 0, sid, cut);
	endtask

	// Wait until the sender is drained and every owed output has arrived,
	// then let the block come to rest.
	task automatic settle();
		do
			@(posedge clk);
		while (rx_items.size() != 0 || item_ch.valid || outputs_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_echo_skip(input logic [8:0] value);
		@(negedge clk);
		cfg_ch.data  <= value;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		echo_setting = value;
	endtask

	initial begin
		int settings[7];
		int p;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		write_echo_skip(9'd0);

		// Directed: shortest frame, address modes, extended length, negative
		// response with a bad sum, zero length, a payload past the buffer limit,
		// timeouts mid-frame and alone.
		queue_frame(0, 1, 1'b0, 1'b0, 8'h00, NO_CUT);
		queue_frame(2, 2, 1'b0, 1'b1, SID_NEGATIVE, NO_CUT);
		queue_frame(3, 2, 1'b1, 1'b1, 8'hFF, NO_CUT);
		queue_frame(0, 0, 1'b1, 1'b0, 8'h00, NO_CUT);
		queue_frame(0, 130, 1'b1, 1'b0, 8'h22, NO_CUT);
		queue_frame(1, 3, 1'b0, 1'b0, 8'h10, 2);
		rx_items.push_back(item_t'{OP_TIMEOUT, 8'hFF});
		stim_count++;

		// Random phases, one echo setting each; the pause before every write
		// lets all owed outputs drain first.
		settings = '{3, 258, 0, 24, 1, 2, $urandom_range(0, 7)};
		for (p = 0; p < 7; p++) begin
			settle();
			if (p == 6)
				quiet = 1'b1;
			write_echo_skip(9'(settings[p]));
			if (settings[p] > 16) begin
				queue_random_frame();
			end else begin
				stim_count = 0;
				while (stim_count < PHASE_ITEMS)
					queue_random_frame();
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
